@@ src/smd_pkg.sv @@
// ----------------------------------------------------------------------------
// smd_pkg
// Shared types, codes and defaults for the stack with middle delete.
// ----------------------------------------------------------------------------
package smd_pkg;

	// default number of element slots
	localparam int DEFAULT_STACK_DEPTH = 1024;

	// element word width
	localparam int DATA_W = 32;

	// request opcodes
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_DELM  = 2'd2;
	localparam logic [1:0] OP_QUERY = 2'd3;

	// result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// per-field write enables of the node memory
	typedef struct packed {
		logic elem;
		logic next;
		logic prev;
	} node_we_t;

endpackage

@@ src/stack_with_middle_delete_top.sv @@
// ----------------------------------------------------------------------------
// stack_with_middle_delete_top
// Bounded stack of signed words with push, pop, delete-middle and query.
// ----------------------------------------------------------------------------
// A request is taken while idle: the acceptance edge starts the link reads,
// the link and commit states update the doubly linked node memory (its single
// read port serializes the top and middle link reads and its single write
// port the two link updates), and the result state loads the new middle word
// into the output register. The input is ready again while that result waits
// to be taken. Elements sit in slots of a node memory linked both ways;
// a free slot stack recycles slots. Slots never released yet are handed out
// in order from a watermark, so there is no clearing pass after reset.
module stack_with_middle_delete_top #(
	parameter int STACK_DEPTH = smd_pkg::DEFAULT_STACK_DEPTH,
	parameter int SLOT_W      = $clog2(STACK_DEPTH),
	parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 opcode,
	input  logic signed [smd_pkg::DATA_W-1:0] push_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [smd_pkg::DATA_W-1:0] middle_value,
	output logic                       is_empty,
	output logic [CNT_W-1:0]           element_count,
	output logic [1:0]                 status
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_LINK   = 4'b0010,
		S_COMMIT = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

	state_t state_q;

	// stack registers
	logic [SLOT_W-1:0] top_q;
	logic [SLOT_W-1:0] mid_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  watermark_q;

	// request in flight
	logic [1:0]                  op_q;
	logic [1:0]                  status_q;
	logic [smd_pkg::DATA_W-1:0]  value_q;
	logic [SLOT_W-1:0]           slot_q;
	logic [SLOT_W-1:0]           prev_top_q;

	// output register
	logic                        out_valid_q;
	logic [smd_pkg::DATA_W-1:0]  middle_value_q;
	logic                        is_empty_q;
	logic [CNT_W-1:0]            element_count_q;
	logic [1:0]                  status_out_q;

	// memory ports
	logic                        node_re;
	logic [SLOT_W-1:0]           node_raddr;
	logic [smd_pkg::DATA_W-1:0]  rd_elem;
	logic [SLOT_W-1:0]           rd_next;
	logic [SLOT_W-1:0]           rd_prev;
	smd_pkg::node_we_t           node_we;
	logic [SLOT_W-1:0]           node_waddr;
	logic [SLOT_W-1:0]           wd_next;
	logic [SLOT_W-1:0]           wd_prev;

	logic                        free_re;
	logic [SLOT_W-1:0]           free_rdata;
	logic                        free_we;
	logic [SLOT_W-1:0]           free_wdata;

	// derived values
	logic              accept;
	logic              load_out;
	logic [1:0]        eff_op;
	logic [1:0]        eff_status;
	logic [CNT_W-1:0]  free_top_idx;
	logic [CNT_W-1:0]  release_idx;
	logic [SLOT_W-1:0] new_slot;
	logic [SLOT_W-1:0] top_nxt;
	logic [SLOT_W-1:0] mid_nxt;
	logic              count_odd;
	logic              count_is_one;

	assign accept       = in_valid && in_ready;
	assign in_ready     = (state_q == S_IDLE);
	assign load_out     = (state_q == S_RESULT) && (!out_valid_q || out_ready);
	assign count_odd    = count_q[0];
	assign count_is_one = (count_q == CNT_W'(1));

	// free stack top entry index and the index a released slot goes to
	assign free_top_idx = CNT_W'(STACK_DEPTH - 1) - count_q;
	assign release_idx  = CNT_W'(STACK_DEPTH) - count_q;

	// slot for a push: below the watermark the initial order still holds
	assign new_slot = (free_top_idx >= watermark_q) ? free_rdata : count_q[SLOT_W-1:0];

	// decode request against the current fill
	always_comb begin
		eff_op     = opcode;
		eff_status = smd_pkg::ST_DONE;
		case (opcode)
			smd_pkg::OP_PUSH: begin
				if (count_q == CNT_W'(STACK_DEPTH)) begin
					eff_op     = smd_pkg::OP_QUERY;
					eff_status = smd_pkg::ST_FULL;
				end
			end
			smd_pkg::OP_POP: begin
				if (count_q == '0) begin
					eff_op     = smd_pkg::OP_QUERY;
					eff_status = smd_pkg::ST_EMPTY;
				end
			end
			smd_pkg::OP_DELM: begin
				if (count_q == '0) begin
					eff_op     = smd_pkg::OP_QUERY;
					eff_status = smd_pkg::ST_EMPTY;
				end else if (count_q <= CNT_W'(2)) begin
					// the middle is the top element
					eff_op = smd_pkg::OP_POP;
				end
			end
			default: begin
				eff_op = smd_pkg::OP_QUERY;
			end
		endcase
	end

	// next top and middle, applied at the commit step
	always_comb begin
		top_nxt = top_q;
		mid_nxt = mid_q;
		case (op_q)
			smd_pkg::OP_PUSH: begin
				top_nxt = slot_q;
				if (count_q == '0) begin
					mid_nxt = slot_q;
				end else if (count_odd) begin
					// with one element the old top's up link is the new slot
					mid_nxt = (mid_q == top_q) ? slot_q : rd_next;
				end
			end
			smd_pkg::OP_POP: begin
				if (count_is_one) begin
					top_nxt = '0;
					mid_nxt = '0;
				end else begin
					top_nxt = prev_top_q;
					if (!count_odd) begin
						mid_nxt = rd_prev;
					end
				end
			end
			smd_pkg::OP_DELM: begin
				mid_nxt = count_odd ? rd_next : rd_prev;
			end
			default: begin
				top_nxt = top_q;
				mid_nxt = mid_q;
			end
		endcase
	end

	// node memory access per step
	always_comb begin
		node_re    = 1'b0;
		node_raddr = mid_q;
		node_we    = '0;
		node_waddr = new_slot;
		wd_next    = slot_q;
		wd_prev    = top_q;
		case (state_q)
			S_IDLE: begin
				node_re    = accept;
				node_raddr = (eff_op == smd_pkg::OP_POP) ? top_q : mid_q;
			end
			S_LINK: begin
				if (op_q == smd_pkg::OP_POP) begin
					node_re    = 1'b1;
					node_raddr = mid_q;
				end else if (op_q == smd_pkg::OP_PUSH) begin
					// new node: word and down link
					node_we.elem = 1'b1;
					node_we.prev = 1'b1;
					node_waddr   = new_slot;
					wd_prev      = top_q;
				end else if (op_q == smd_pkg::OP_DELM) begin
					// unlink: node above points down past the middle
					node_we.prev = 1'b1;
					node_waddr   = rd_next;
					wd_prev      = rd_prev;
				end
			end
			S_COMMIT: begin
				node_re    = 1'b1;
				node_raddr = mid_nxt;
				if (op_q == smd_pkg::OP_PUSH && count_q != '0) begin
					node_we.next = 1'b1;
					node_waddr   = top_q;
					wd_next      = slot_q;
				end else if (op_q == smd_pkg::OP_DELM) begin
					node_we.next = 1'b1;
					node_waddr   = rd_prev;
					wd_next      = rd_next;
				end
			end
			default: begin
				node_re = 1'b0;
			end
		endcase
	end

	// free stack access
	assign free_re    = accept;
	assign free_we    = (state_q == S_COMMIT) &&
	                    (op_q == smd_pkg::OP_POP || op_q == smd_pkg::OP_DELM);
	assign free_wdata = (op_q == smd_pkg::OP_POP) ? top_q : mid_q;

	smd_node_ram #(
		.STACK_DEPTH(STACK_DEPTH),
		.SLOT_W     (SLOT_W)
	) u_node_ram (
		.clk    (clk),
		.re     (node_re),
		.raddr  (node_raddr),
		.rd_elem(rd_elem),
		.rd_next(rd_next),
		.rd_prev(rd_prev),
		.we     (node_we),
		.waddr  (node_waddr),
		.wd_elem(value_q),
		.wd_next(wd_next),
		.wd_prev(wd_prev)
	);

	smd_free_ram #(
		.STACK_DEPTH(STACK_DEPTH),
		.SLOT_W     (SLOT_W)
	) u_free_ram (
		.clk  (clk),
		.re   (free_re),
		.raddr(free_top_idx[SLOT_W-1:0]),
		.rdata(free_rdata),
		.we   (free_we),
		.waddr(release_idx[SLOT_W-1:0]),
		.wdata(free_wdata)
	);

	// sequencer and stack registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= '0;
			mid_q       <= '0;
			count_q     <= '0;
			watermark_q <= CNT_W'(STACK_DEPTH);
			op_q        <= smd_pkg::OP_QUERY;
			status_q    <= smd_pkg::ST_DONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= eff_op;
						status_q <= eff_status;
						state_q  <= S_LINK;
					end
				end
				S_LINK: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					top_q <= top_nxt;
					mid_q <= mid_nxt;
					if (op_q == smd_pkg::OP_PUSH) begin
						count_q <= count_q + CNT_W'(1);
					end else if (op_q == smd_pkg::OP_POP || op_q == smd_pkg::OP_DELM) begin
						count_q <= count_q - CNT_W'(1);
						if (release_idx < watermark_q) begin
							watermark_q <= release_idx;
						end
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload of the request in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= push_value;
		end
		if (state_q == S_LINK) begin
			slot_q     <= new_slot;
			prev_top_q <= rd_prev;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			middle_value_q  <= (count_q == '0) ? '1 : rd_elem;
			is_empty_q      <= (count_q == '0);
			element_count_q <= count_q;
			status_out_q    <= status_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign middle_value  = middle_value_q;
	assign is_empty      = is_empty_q;
	assign element_count = element_count_q;
	assign status        = status_out_q;

endmodule

@@ src/smd_node_ram.sv @@
// ----------------------------------------------------------------------------
// smd_node_ram
// Node memory: element word plus links up and down, one read port with
// registered data and one write port with a write enable per field.
// ----------------------------------------------------------------------------
module smd_node_ram #(
	parameter int STACK_DEPTH = smd_pkg::DEFAULT_STACK_DEPTH,
	parameter int SLOT_W      = $clog2(STACK_DEPTH)
) (
	input  logic                      clk,
	input  logic                      re,
	input  logic [SLOT_W-1:0]         raddr,
	output logic [smd_pkg::DATA_W-1:0] rd_elem,
	output logic [SLOT_W-1:0]         rd_next,
	output logic [SLOT_W-1:0]         rd_prev,
	input  smd_pkg::node_we_t         we,
	input  logic [SLOT_W-1:0]         waddr,
	input  logic [smd_pkg::DATA_W-1:0] wd_elem,
	input  logic [SLOT_W-1:0]         wd_next,
	input  logic [SLOT_W-1:0]         wd_prev
);

	logic [smd_pkg::DATA_W-1:0] mem_elem [STACK_DEPTH];
	logic [SLOT_W-1:0]          mem_next [STACK_DEPTH];
	logic [SLOT_W-1:0]          mem_prev [STACK_DEPTH];

	// field writes
	always_ff @(posedge clk) begin
		if (we.elem) begin
			mem_elem[waddr] <= wd_elem;
		end
		if (we.next) begin
			mem_next[waddr] <= wd_next;
		end
		if (we.prev) begin
			mem_prev[waddr] <= wd_prev;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rd_elem <= mem_elem[raddr];
			rd_next <= mem_next[raddr];
			rd_prev <= mem_prev[raddr];
		end
	end

endmodule

@@ src/smd_free_ram.sv @@
// ----------------------------------------------------------------------------
// smd_free_ram
// Free slot stack memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module smd_free_ram #(
	parameter int STACK_DEPTH = smd_pkg::DEFAULT_STACK_DEPTH,
	parameter int SLOT_W      = $clog2(STACK_DEPTH)
) (
	input  logic              clk,
	input  logic              re,
	input  logic [SLOT_W-1:0] raddr,
	output logic [SLOT_W-1:0] rdata,
	input  logic              we,
	input  logic [SLOT_W-1:0] waddr,
	input  logic [SLOT_W-1:0] wdata
);

	logic [SLOT_W-1:0] mem [STACK_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/smd_checker.sv @@
// ----------------------------------------------------------------------------
// smd_checker
// Port-level checks of the stack with middle delete, bound to the top level.
// ----------------------------------------------------------------------------
module smd_checker #(
	parameter int STACK_DEPTH = smd_pkg::DEFAULT_STACK_DEPTH,
	parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [smd_pkg::DATA_W-1:0] middle_value,
	input logic                       is_empty,
	input logic [CNT_W-1:0]           element_count,
	input logic [1:0]                 status
);

	// a stalled result item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(middle_value) &&
		$stable(element_count) && $stable(status))
	else $error("stalled result item changed");

	// empty flag agrees with the count
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_empty == (element_count == '0))
	else $error("empty flag disagrees with count");

	// an empty stack reports all ones as middle
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> middle_value == '1)
	else $error("empty stack middle is not minus one");

	// a refused push only happens when full
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == smd_pkg::ST_FULL |-> element_count == CNT_W'(STACK_DEPTH))
	else $error("push refused while not full");

	// an ignored pop or delete leaves the stack empty
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == smd_pkg::ST_EMPTY |-> is_empty)
	else $error("empty status on a non-empty stack");

endmodule

bind stack_with_middle_delete_top smd_checker #(
	.STACK_DEPTH(STACK_DEPTH),
	.CNT_W      (CNT_W)
) u_smd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.middle_value (middle_value),
	.is_empty     (is_empty),
	.element_count(element_count),
	.status       (status)
);
